// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the checker files
// expects signals clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lpc_pkg.sv -----
// shared types and constants of the lexical path cleaner
// no dependencies
package lpc_pkg;

	localparam int MAX_PATH_BYTES_DEF = 1024;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] SEP_BYTE = 8'h2F;
	localparam logic [7:0] DOT_BYTE = 8'h2E;

	typedef struct packed {
		logic       is_read;
		logic       last;
		logic       is_sep;
		logic       is_dot;
		logic [7:0] ch;
	} op_t;

endpackage

// ----- rtl/core/lpc_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/lpc_front.sv -----
// front end: accepts requests, classifies the byte and queues the operation
// depends on lpc_pkg
module lpc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          action,
	input  logic [7:0]    in_char,
	input  logic          in_last,
	output logic          op_valid,
	input  logic          op_take,
	output lpc_pkg::op_t  op
);

	localparam int QAW = $clog2(lpc_pkg::Q_DEPTH);
	localparam logic [QAW:0] FULL = (QAW+1)'(lpc_pkg::Q_DEPTH);

	lpc_pkg::op_t q_q [lpc_pkg::Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	lpc_pkg::op_t   op_new;
	logic           push;
	logic           pop;

	always_comb begin
		op_new.is_read = action;
		op_new.last    = in_last;
		op_new.is_sep  = (in_char == lpc_pkg::SEP_BYTE);
		op_new.is_dot  = (in_char == lpc_pkg::DOT_BYTE);
		op_new.ch      = in_char;
	end

	assign in_stall = (cnt_q == FULL);
	assign op_valid = (cnt_q != '0);
	assign op       = q_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = op_take && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= op_new;
		end
	end

endmodule

// ----- rtl/core/lpc_back.sv -----
// back end: path buffer, segment stack and the sequencer that cleans the path
// depends on lpc_pkg and lpc_ram
module lpc_back #(
	parameter int MAX_PATH_BYTES = lpc_pkg::MAX_PATH_BYTES_DEF,
	localparam int LEN_W = $clog2(MAX_PATH_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  lpc_pkg::op_t     op,
	output logic             op_take,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_char,
	output logic             out_valid,
	output logic             out_last,
	output logic             path_done,
	output logic [LEN_W-1:0] out_length,
	output logic             overflow
);

	localparam int AW = $clog2(MAX_PATH_BYTES);
	localparam int STK_DEPTH = MAX_PATH_BYTES / 2;
	localparam int SAW = $clog2(STK_DEPTH);
	localparam int SCW = SAW + 1;
	localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PATH_BYTES);
	localparam logic [LEN_W-1:0] ONE_L = LEN_W'(1);
	localparam logic [SCW-1:0] STK_L = SCW'(STK_DEPTH);

	typedef enum logic [1:0] {
		CLS_EMPTY,
		CLS_DOT,
		CLS_DOTDOT,
		CLS_OTHER
	} seg_class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP1,
		ST_FINAL,
		ST_POP2,
		ST_RESP
	} state_t;

	state_t           state_q, state_d;
	lpc_pkg::op_t     cur_q, cur_d;
	logic [LEN_W-1:0] ic_q, ic_d;
	logic [LEN_W-1:0] wp_q, wp_d;
	logic [LEN_W-1:0] ss_q, ss_d;
	seg_class_t       cls_q, cls_d;
	logic             rel_q, rel_d;
	logic [SCW-1:0]   sc_q, sc_d;
	logic [LEN_W-1:0] rp_q, rp_d;
	logic             ovf_q, ovf_d;
	logic             done_q, done_d;
	logic             hit_q, hit_d;
	logic             res_valid_q, res_valid_d;
	logic [7:0]       res_char_q, res_char_d;
	logic             res_ov_q, res_ov_d;
	logic             res_last_q, res_last_d;
	logic             res_done_q, res_done_d;
	logic [LEN_W-1:0] res_len_q, res_len_d;
	logic             res_ovf_q, res_ovf_d;

	// state as seen by a push, after the clear that follows a finished path
	logic [LEN_W-1:0] e_ic, e_wp, e_ss;
	seg_class_t       e_cls;
	logic             e_rel, e_ovf;
	logic [SCW-1:0]   e_sc;
	logic [LEN_W-1:0] wp_put;
	logic [SCW-1:0]   sc_dec_e, sc_dec_q;
	logic [LEN_W-1:0] rp_inc;
	logic             fin;

	logic             buf_we, buf_re;
	logic [AW-1:0]    buf_waddr, buf_raddr;
	logic [7:0]       buf_wdata, buf_rdata;
	logic             stk_we, stk_re;
	logic [SAW-1:0]   stk_waddr, stk_raddr;
	logic [LEN_W-1:0] stk_wdata, stk_rdata;

	lpc_ram #(.WIDTH(8), .DEPTH(MAX_PATH_BYTES)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	lpc_ram #(.WIDTH(LEN_W), .DEPTH(STK_DEPTH)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign e_ic     = done_q ? '0 : ic_q;
	assign e_wp     = done_q ? ONE_L : wp_q;
	assign e_ss     = done_q ? ONE_L : ss_q;
	assign e_cls    = done_q ? CLS_EMPTY : cls_q;
	assign e_rel    = done_q ? 1'b0 : rel_q;
	assign e_ovf    = done_q ? 1'b0 : ovf_q;
	assign e_sc     = done_q ? '0 : sc_q;
	assign wp_put   = (e_wp < MAX_L) ? e_wp + 1'b1 : e_wp;
	assign sc_dec_e = e_sc - 1'b1;
	assign sc_dec_q = sc_q - 1'b1;
	assign rp_inc   = rp_q + 1'b1;
	assign fin      = done_q || (!cur_q.is_read && cur_q.last);

	always_comb begin
		logic [LEN_W-1:0] w;
		logic             pop_n;

		state_d     = state_q;
		cur_d       = cur_q;
		ic_d        = ic_q;
		wp_d        = wp_q;
		ss_d        = ss_q;
		cls_d       = cls_q;
		rel_d       = rel_q;
		sc_d        = sc_q;
		rp_d        = rp_q;
		ovf_d       = ovf_q;
		done_d      = done_q;
		hit_d       = hit_q;
		res_valid_d = res_valid_q && res_stall;
		res_char_d  = res_char_q;
		res_ov_d    = res_ov_q;
		res_last_d  = res_last_q;
		res_done_d  = res_done_q;
		res_len_d   = res_len_q;
		res_ovf_d   = res_ovf_q;
		op_take     = 1'b0;
		buf_we      = 1'b0;
		buf_waddr   = '0;
		buf_wdata   = '0;
		buf_re      = 1'b0;
		buf_raddr   = '0;
		stk_we      = 1'b0;
		stk_waddr   = '0;
		stk_wdata   = '0;
		stk_re      = 1'b0;
		stk_raddr   = '0;
		w           = wp_q;
		pop_n       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_take = 1'b1;
					cur_d   = op;
					if (op.is_read) begin
						hit_d = done_q && (rp_q < wp_q);
						if (done_q && (rp_q < wp_q)) begin
							buf_re    = 1'b1;
							buf_raddr = rp_q[AW-1:0];
						end
						state_d = ST_RESP;
					end else begin
						ic_d   = e_ic;
						wp_d   = e_wp;
						ss_d   = e_ss;
						cls_d  = e_cls;
						rel_d  = e_rel;
						sc_d   = e_sc;
						ovf_d  = e_ovf;
						done_d = 1'b0;
						if (done_q) begin
							rp_d = '0;
						end
						if (e_ic == MAX_L) begin
							ovf_d = 1'b1;
						end else begin
							ic_d = e_ic + 1'b1;
							if (e_ic == '0) begin
								// first byte decides absolute or pass-through
								buf_we    = 1'b1;
								buf_waddr = '0;
								buf_wdata = op.ch;
								wp_d      = ONE_L;
								ss_d      = ONE_L;
								cls_d     = CLS_EMPTY;
								rel_d     = !op.is_sep;
							end else if (e_rel) begin
								if (e_wp < MAX_L) begin
									buf_we    = 1'b1;
									buf_waddr = e_wp[AW-1:0];
									buf_wdata = op.ch;
								end
								wp_d = wp_put;
							end else if (op.is_sep) begin
								cls_d = CLS_EMPTY;
								case (e_cls)
									CLS_DOT: begin
										wp_d = e_ss;
										ss_d = e_ss;
									end
									CLS_DOTDOT: begin
										if (e_sc != '0) begin
											stk_re    = 1'b1;
											stk_raddr = sc_dec_e[SAW-1:0];
											sc_d      = sc_dec_e;
											pop_n     = 1'b1;
										end else begin
											wp_d = e_ss;
											ss_d = e_ss;
										end
									end
									CLS_OTHER: begin
										if (e_sc < STK_L) begin
											stk_we    = 1'b1;
											stk_waddr = e_sc[SAW-1:0];
											stk_wdata = e_ss;
											sc_d      = e_sc + 1'b1;
										end
										if (e_wp < MAX_L) begin
											buf_we    = 1'b1;
											buf_waddr = e_wp[AW-1:0];
											buf_wdata = lpc_pkg::SEP_BYTE;
										end
										wp_d = wp_put;
										ss_d = wp_put;
									end
									default: begin
										ss_d = e_wp;
									end
								endcase
							end else begin
								if (e_wp < MAX_L) begin
									buf_we    = 1'b1;
									buf_waddr = e_wp[AW-1:0];
									buf_wdata = op.ch;
								end
								wp_d = wp_put;
								if (op.is_dot && e_cls == CLS_EMPTY) begin
									cls_d = CLS_DOT;
								end else if (op.is_dot && e_cls == CLS_DOT) begin
									cls_d = CLS_DOTDOT;
								end else begin
									cls_d = CLS_OTHER;
								end
							end
						end
						if (pop_n) begin
							state_d = ST_POP1;
						end else if (op.last && !rel_d) begin
							state_d = ST_FINAL;
						end else begin
							state_d = ST_RESP;
						end
					end
				end
			end
			ST_POP1: begin
				wp_d    = stk_rdata;
				ss_d    = stk_rdata;
				cls_d   = CLS_EMPTY;
				state_d = cur_q.last ? ST_FINAL : ST_RESP;
			end
			ST_FINAL: begin
				if (cls_q == CLS_DOTDOT && sc_q != '0) begin
					stk_re    = 1'b1;
					stk_raddr = sc_dec_q[SAW-1:0];
					sc_d      = sc_dec_q;
					state_d   = ST_POP2;
				end else begin
					w = (cls_q == CLS_DOT || cls_q == CLS_DOTDOT) ? ss_q : wp_q;
					if (cls_q != CLS_OTHER && w > ONE_L) begin
						w = w - 1'b1;
					end
					wp_d    = w;
					ss_d    = w;
					cls_d   = CLS_EMPTY;
					state_d = ST_RESP;
				end
			end
			ST_POP2: begin
				w = stk_rdata;
				if (w > ONE_L) begin
					w = w - 1'b1;
				end
				wp_d    = w;
				ss_d    = w;
				cls_d   = CLS_EMPTY;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!res_valid_q || !res_stall) begin
					res_valid_d = 1'b1;
					res_char_d  = (cur_q.is_read && hit_q) ? buf_rdata : '0;
					res_ov_d    = cur_q.is_read && hit_q;
					res_last_d  = cur_q.is_read && hit_q && (rp_inc == wp_q);
					if (cur_q.is_read && hit_q) begin
						rp_d = rp_inc;
					end
					done_d     = fin;
					res_done_d = fin;
					res_len_d  = wp_q;
					res_ovf_d  = ovf_q;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			ic_q        <= '0;
			wp_q        <= ONE_L;
			ss_q        <= ONE_L;
			cls_q       <= CLS_EMPTY;
			rel_q       <= 1'b0;
			sc_q        <= '0;
			rp_q        <= '0;
			ovf_q       <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_char_q  <= '0;
			res_ov_q    <= 1'b0;
			res_last_q  <= 1'b0;
			res_done_q  <= 1'b0;
			res_len_q   <= '0;
			res_ovf_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			ic_q        <= ic_d;
			wp_q        <= wp_d;
			ss_q        <= ss_d;
			cls_q       <= cls_d;
			rel_q       <= rel_d;
			sc_q        <= sc_d;
			rp_q        <= rp_d;
			ovf_q       <= ovf_d;
			done_q      <= done_d;
			hit_q       <= hit_d;
			res_valid_q <= res_valid_d;
			res_char_q  <= res_char_d;
			res_ov_q    <= res_ov_d;
			res_last_q  <= res_last_d;
			res_done_q  <= res_done_d;
			res_len_q   <= res_len_d;
			res_ovf_q   <= res_ovf_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign out_char   = res_char_q;
	assign out_valid  = res_ov_q;
	assign out_last   = res_last_q;
	assign path_done  = res_done_q;
	assign out_length = res_len_q;
	assign overflow   = res_ovf_q;

endmodule

// ----- rtl/core/lexical_path_cleaner_unit.sv -----
// Lexical path cleaner. Each request either pushes one path byte (action 0) or
// reads one cleaned byte (action 1), and each request returns exactly one
// response. A front end queues up to two classified requests so input and
// output stall independently; the back end works on one request at a time.
// A read or an ordinary push goes from the idle state to the response state;
// the byte that ends an absolute path also passes the final state; a ".." pop
// adds a stack-read state for the registered read of the segment stack memory,
// and both apply to a ".." at the path end, closed by a separator or not.
// No clearing pass after reset is needed.
// depends on lpc_pkg, lpc_front, lpc_back
module lexical_path_cleaner_unit #(
	parameter int MAX_PATH_BYTES = lpc_pkg::MAX_PATH_BYTES_DEF,
	localparam int LEN_W = $clog2(MAX_PATH_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             action,
	input  logic [7:0]       in_char,
	input  logic             in_last,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_char,
	output logic             out_valid,
	output logic             out_last,
	output logic             path_done,
	output logic [LEN_W-1:0] out_length,
	output logic             overflow
);

	lpc_pkg::op_t op;
	logic         op_valid;
	logic         op_take;

	lpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.in_char  (in_char),
		.in_last  (in_last),
		.op_valid (op_valid),
		.op_take  (op_take),
		.op       (op)
	);

	lpc_back #(.MAX_PATH_BYTES(MAX_PATH_BYTES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op         (op),
		.op_take    (op_take),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_char   (out_char),
		.out_valid  (out_valid),
		.out_last   (out_last),
		.path_done  (path_done),
		.out_length (out_length),
		.overflow   (overflow)
	);

endmodule

// ----- rtl/core/lpc_checker.sv -----
// port-level checks of the lexical path cleaner, bound to the top level
// depends on assert_macros.svh, lpc_pkg and lexical_path_cleaner_unit
`include "assert_macros.svh"

module lpc_checker #(
	parameter int MAX_PATH_BYTES = lpc_pkg::MAX_PATH_BYTES_DEF,
	localparam int LEN_W = $clog2(MAX_PATH_BYTES + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             action,
	input logic [7:0]       in_char,
	input logic             in_last,
	input logic             res_valid,
	input logic             res_stall,
	input logic [7:0]       out_char,
	input logic             out_valid,
	input logic             out_last,
	input logic             path_done,
	input logic [LEN_W-1:0] out_length,
	input logic             overflow
);

	// a byte is only returned from a finished path
	`ASSERT_IMPLIES(a_byte_needs_done, res_valid && out_valid, path_done, "byte before path done")

	// the final byte is a real byte of a non-empty path
	`ASSERT_IMPLIES(a_last_is_byte, res_valid && out_last, out_valid && out_length != '0, "bad last flag")

	// stalled response holds its char, length and overflow
	`ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_char) && $stable(out_length) && $stable(overflow), "response changed under stall")

	// stalled request holds
	`ASSERT_NEXT(a_req_hold, in_valid && in_stall, in_valid && $stable(action) && $stable(in_char) && $stable(in_last), "request changed under stall")

endmodule

bind lexical_path_cleaner_unit lpc_checker #(.MAX_PATH_BYTES(MAX_PATH_BYTES)) u_lpc_checker (.*);

// ----- bench/lexical_path_cleaner_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for lexical_path_cleaner_unit: push and read requests with random gaps and stalls,
// every response checked against a path-cleaning predictor kept in step with accepted requests
// depends on lpc_pkg and lexical_path_cleaner_unit
module lexical_path_cleaner_unit_tb;

	localparam int MAX_BYTES = lpc_pkg::MAX_PATH_BYTES_DEF;
	localparam int LEN_W = $clog2(MAX_BYTES + 1);
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [1:0] {KIND_EMPTY, KIND_DOT, KIND_DOTDOT, KIND_NAME} seg_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	typedef struct packed {
		logic       pause;
		logic       act;
		logic [7:0] ch;
		logic       last;
	} path_req_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic             valid;
		logic             last;
		logic             done;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} clean_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             action = ACT_PUSH;
	logic [7:0]       in_char = 8'h00;
	logic             in_last = 1'b0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [7:0]       out_char;
	logic             out_valid;
	logic             out_last;
	logic             path_done;
	logic [LEN_W-1:0] out_length;
	logic             overflow;

	lexical_path_cleaner_unit #(.MAX_PATH_BYTES(MAX_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.in_char(in_char),
		.in_last(in_last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_char(out_char),
		.out_valid(out_valid),
		.out_last(out_last),
		.path_done(path_done),
		.out_length(out_length),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	path_req_t   req_q[$];
	clean_res_t  clean_q[$];
	path_req_t   next_req;
	clean_res_t  want;
	int          errors = 0;
	int          results_seen = 0;
	int          n_items = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          mode_left = 0;
	int          hold_left = 0;
	bit          held_once = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;

	// predictor state
	logic [7:0]  path_mem[MAX_BYTES];
	int unsigned seg_starts[MAX_BYTES / 2];
	int unsigned seg_depth;
	int unsigned wr_ptr;
	int unsigned seg_begin;
	seg_kind_t   seg_kind;
	bit          relative;
	int unsigned byte_cnt;
	int unsigned rd_ptr;
	bit          ovf;
	bit          done;

	function automatic void reset_path();
		seg_depth = 0;
		wr_ptr = 1;
		seg_begin = 1;
		seg_kind = KIND_EMPTY;
		relative = 1'b0;
		byte_cnt = 0;
		rd_ptr = 0;
		ovf = 1'b0;
		done = 1'b0;
	endfunction

	function automatic void append_byte(logic [7:0] c);
		if (wr_ptr < MAX_BYTES) begin
			path_mem[wr_ptr] = c;
			wr_ptr++;
		end
	endfunction

	function automatic void close_seg(bit at_end);
		seg_kind_t k;
		k = seg_kind;
		if (k == KIND_DOT) begin
			wr_ptr = seg_begin;
		end else if (k == KIND_DOTDOT) begin
			wr_ptr = seg_begin;
			if (seg_depth > 0) begin
				seg_depth--;
				wr_ptr = seg_starts[seg_depth];
			end
		end else if (k == KIND_NAME && !at_end) begin
			if (seg_depth < MAX_BYTES / 2) begin
				seg_starts[seg_depth] = seg_begin;
				seg_depth++;
			end
			append_byte(lpc_pkg::SEP_BYTE);
		end
		if (at_end && k != KIND_NAME && wr_ptr > 1)
			wr_ptr--;
		seg_begin = wr_ptr;
		seg_kind = KIND_EMPTY;
	endfunction

	function automatic clean_res_t clean_step(logic act, logic [7:0] ch, logic last);
		clean_res_t r;
		r = '0;
		if (act == ACT_PUSH) begin
			if (done)
				reset_path();
			if (byte_cnt >= MAX_BYTES) begin
				ovf = 1'b1;
			end else begin
				byte_cnt++;
				if (byte_cnt == 1) begin
					path_mem[0] = ch;
					wr_ptr = 1;
					seg_begin = 1;
					seg_kind = KIND_EMPTY;
					relative = (ch != lpc_pkg::SEP_BYTE);
				end else if (relative) begin
					append_byte(ch);
				end else if (ch == lpc_pkg::SEP_BYTE) begin
					close_seg(1'b0);
				end else begin
					append_byte(ch);
					if (ch == lpc_pkg::DOT_BYTE && seg_kind == KIND_EMPTY)
						seg_kind = KIND_DOT;
					else if (ch == lpc_pkg::DOT_BYTE && seg_kind == KIND_DOT)
						seg_kind = KIND_DOTDOT;
					else
						seg_kind = KIND_NAME;
				end
			end
			if (last) begin
				if (byte_cnt > 0 && !relative)
					close_seg(1'b1);
				done = 1'b1;
			end
		end else if (done && rd_ptr < wr_ptr && rd_ptr < MAX_BYTES) begin
			r.ch = path_mem[rd_ptr];
			r.valid = 1'b1;
			r.last = (rd_ptr + 1 == wr_ptr);
			rd_ptr++;
		end
		r.done = done;
		r.len = LEN_W'(wr_ptr);
		r.ovf = ovf;
		return r;
	endfunction

	function automatic void check_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, fname, exp_v, act_v);
		end
	endfunction

	// stimulus helpers
	task automatic queue_req(logic act, logic [7:0] ch, logic last);
		req_q.insert(req_q.size(), '{pause: 1'b0, act: act, ch: ch, last: last});
		n_items++;
	endtask

	task automatic queue_pause();
		req_q.insert(req_q.size(), '{pause: 1'b1, act: ACT_PUSH, ch: 8'h00, last: 1'b0});
	endtask

	task automatic queue_reads(int n);
		repeat (n) queue_req(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_path(logic [7:0] p[$], int n_reads, bit stray);
		foreach (p[i]) begin
			if (stray && i > 0 && $urandom_range(0, 29) == 0)
				queue_reads(1);
			queue_req(ACT_PUSH, p[i], i == p.size() - 1);
		end
		queue_reads(n_reads);
	endtask

	task automatic send_text(string s, int n_reads);
		logic [7:0] p[$];
		for (int i = 0; i < s.len(); i++)
			p.insert(p.size(), s[i]);
		send_path(p, n_reads, 1'b0);
	endtask

	task automatic add_name(ref logic [7:0] p[$]);
		int n;
		int r;
		n = $urandom_range(1, 5);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				p.insert(p.size(), 8'(8'h61 + $urandom_range(0, 25)));
			else if (r < 8)
				p.insert(p.size(), lpc_pkg::DOT_BYTE);
			else
				p.insert(p.size(), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_segment(ref logic [7:0] p[$]);
		case ($urandom_range(0, 5))
			0: ;
			1: p.insert(p.size(), lpc_pkg::DOT_BYTE);
			2, 3: begin
				p.insert(p.size(), lpc_pkg::DOT_BYTE);
				p.insert(p.size(), lpc_pkg::DOT_BYTE);
			end
			default: add_name(p);
		endcase
		p.insert(p.size(), lpc_pkg::SEP_BYTE);
	endtask

	task automatic build_stimulus();
		logic [7:0] p[$];
		int target;
		int last_pause;
		int sel;

		// directed
		queue_reads(1);
		send_text("/", 2);
		send_text("/..", 1);
		queue_req(ACT_PUSH, lpc_pkg::SEP_BYTE, 1'b0);
		queue_req(ACT_PUSH, 8'h61, 1'b0);
		queue_reads(1);
		queue_req(ACT_PUSH, lpc_pkg::SEP_BYTE, 1'b0);
		queue_req(ACT_PUSH, lpc_pkg::SEP_BYTE, 1'b0);
		queue_req(ACT_PUSH, lpc_pkg::DOT_BYTE, 1'b1);
		queue_reads(2);
		p = '{lpc_pkg::SEP_BYTE, 8'hFF, 8'h00, lpc_pkg::SEP_BYTE, lpc_pkg::DOT_BYTE,
			lpc_pkg::DOT_BYTE, lpc_pkg::DOT_BYTE};
		send_path(p, 1, 1'b0);
		send_text("x/..", 5);
		queue_pause();

		// random
		target = n_items + 950;
		last_pause = n_items;
		while (n_items < target) begin
			p.delete();
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				p.insert(p.size(), lpc_pkg::SEP_BYTE);
				repeat ($urandom_range(0, 6)) add_segment(p);
				if (p.size() > 1 && $urandom_range(0, 1))
					p.delete(p.size() - 1);
			end else if (sel < 90) begin
				add_name(p);
				repeat ($urandom_range(0, 3)) begin
					p.insert(p.size(), lpc_pkg::SEP_BYTE);
					add_segment(p);
				end
			end else if (sel < 95) begin
				repeat ($urandom_range(1, 8)) p.insert(p.size(), 8'($urandom_range(0, 255)));
			end else begin
				p.insert(p.size(),
					($urandom_range(0, 1)) ? lpc_pkg::SEP_BYTE : 8'($urandom_range(0, 255)));
			end
			send_path(p, ($urandom_range(0, 3) == 0) ? $urandom_range(0, p.size()) : p.size() + 1,
				1'b1);
			if ($urandom_range(0, 9) == 0)
				queue_reads($urandom_range(1, 3));
			if (n_items - last_pause >= 200) begin
				queue_pause();
				last_pause = n_items;
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_PUSH;
			in_char <= 8'h00;
			in_last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				clean_q.insert(clean_q.size(), clean_step(action, in_char, in_last));
			if (!in_valid || !in_stall) begin
				if (req_q.size() > 0 && req_q[0].pause && clean_q.size() == 0)
					void'(req_q.pop_front());
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (req_q.size() == 0 || req_q[0].pause) begin
					in_valid <= 1'b0;
				end else begin
					next_req = req_q.pop_front();
					in_valid <= 1'b1;
					action <= next_req.act;
					in_char <= next_req.ch;
					in_last <= next_req.last;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// response stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!held_once && results_seen >= 300) begin
			held_once <= 1'b1;
			hold_left <= 400;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(32, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE: res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				default: res_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (clean_q.size() == 0) begin
				errors++;
				$display("%0t: response expected none got char %h valid %b last %b len %0d",
					$time, out_char, out_valid, out_last, out_length);
			end else begin
				want = clean_q.pop_front();
				check_field("out_char", want.ch, out_char);
				check_field("out_valid", want.valid, out_valid);
				check_field("out_last", want.last, out_last);
				check_field("path_done", want.done, path_done);
				check_field("out_length", want.len, out_length);
				check_field("overflow", want.ovf, overflow);
			end
		end
	end

	initial begin
		reset_path();
		build_stimulus();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (req_q.size() == 0);
		@(posedge clk);
		wait (!in_valid);
		wait (clean_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
